[src/seed_block_cipher_unit_defines.svh]
// Assertion macros shared by the checker
`ifndef SEED_BLOCK_CIPHER_UNIT_DEFINES_SVH
`define SEED_BLOCK_CIPHER_UNIT_DEFINES_SVH

// implication checked on every clock edge outside reset
`define SEED_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// implication checked in the cycle after the antecedent
`define SEED_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/seed_pkg.sv]
package seed_pkg;

  typedef struct packed {
    logic        cmd;
    logic [63:0] block_high;
    logic [63:0] block_low;
  } seed_in_t;

  typedef struct packed {
    logic [63:0] out_high;
    logic [63:0] out_low;
  } seed_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_KEY,
    ST_G0,
    ST_G1,
    ST_G2,
    ST_DONE
  } seed_state_t;

  localparam logic [1:0] CFG_KEY_HIGH = 2'd0;
  localparam logic [1:0] CFG_KEY_LOW  = 2'd1;
  localparam logic       CMD_DECRYPT  = 1'b1;
  localparam logic [31:0] GOLDEN_KC   = 32'h9e3779b9;

  localparam logic [7:0] MASK_A = 8'hfc;
  localparam logic [7:0] MASK_B = 8'hf3;
  localparam logic [7:0] MASK_C = 8'hcf;
  localparam logic [7:0] MASK_D = 8'h3f;

  localparam logic [7:0] SBOX_ONE [256] = '{
    8'hA9,8'h85,8'hD6,8'hD3,8'h54,8'h1D,8'hAC,8'h25,8'h5D,8'h43,8'h18,8'h1E,8'h51,8'hFC,8'hCA,8'h63,
    8'h28,8'h44,8'h20,8'h9D,8'hE0,8'hE2,8'hC8,8'h17,8'hA5,8'h8F,8'h03,8'h7B,8'hBB,8'h13,8'hD2,8'hEE,
    8'h70,8'h8C,8'h3F,8'hA8,8'h32,8'hDD,8'hF6,8'h74,8'hEC,8'h95,8'h0B,8'h57,8'h5C,8'h5B,8'hBD,8'h01,
    8'h24,8'h1C,8'h73,8'h98,8'h10,8'hCC,8'hF2,8'hD9,8'h2C,8'hE7,8'h72,8'h83,8'h9B,8'hD1,8'h86,8'hC9,
    8'h60,8'h50,8'hA3,8'hEB,8'h0D,8'hB6,8'h9E,8'h4F,8'hB7,8'h5A,8'hC6,8'h78,8'hA6,8'h12,8'hAF,8'hD5,
    8'h61,8'hC3,8'hB4,8'h41,8'h52,8'h7D,8'h8D,8'h08,8'h1F,8'h99,8'h00,8'h19,8'h04,8'h53,8'hF7,8'hE1,
    8'hFD,8'h76,8'h2F,8'h27,8'hB0,8'h8B,8'h0E,8'hAB,8'hA2,8'h6E,8'h93,8'h4D,8'h69,8'h7C,8'h09,8'h0A,
    8'hBF,8'hEF,8'hF3,8'hC5,8'h87,8'h14,8'hFE,8'h64,8'hDE,8'h2E,8'h4B,8'h1A,8'h06,8'h21,8'h6B,8'h66,
    8'h02,8'hF5,8'h92,8'h8A,8'h0C,8'hB3,8'h7E,8'hD0,8'h7A,8'h47,8'h96,8'hE5,8'h26,8'h80,8'hAD,8'hDF,
    8'hA1,8'h30,8'h37,8'hAE,8'h36,8'h15,8'h22,8'h38,8'hF4,8'hA7,8'h45,8'h4C,8'h81,8'hE9,8'h84,8'h97,
    8'h35,8'hCB,8'hCE,8'h3C,8'h71,8'h11,8'hC7,8'h89,8'h75,8'hFB,8'hDA,8'hF8,8'h94,8'h59,8'h82,8'hC4,
    8'hFF,8'h49,8'h39,8'h67,8'hC0,8'hCF,8'hD7,8'hB8,8'h0F,8'h8E,8'h42,8'h23,8'h91,8'h6C,8'hDB,8'hA4,
    8'h34,8'hF1,8'h48,8'hC2,8'h6F,8'h3D,8'h2D,8'h40,8'hBE,8'h3E,8'hBC,8'hC1,8'hAA,8'hBA,8'h4E,8'h55,
    8'h3B,8'hDC,8'h68,8'h7F,8'h9C,8'hD8,8'h4A,8'h56,8'h77,8'hA0,8'hED,8'h46,8'hB5,8'h2B,8'h65,8'hFA,
    8'hE3,8'hB9,8'hB1,8'h9F,8'h5E,8'hF9,8'hE6,8'hB2,8'h31,8'hEA,8'h6D,8'h5F,8'hE4,8'hF0,8'hCD,8'h88,
    8'h16,8'h3A,8'h58,8'hD4,8'h62,8'h29,8'h07,8'h33,8'hE8,8'h1B,8'h05,8'h79,8'h90,8'h6A,8'h2A,8'h9A
  };

  localparam logic [7:0] SBOX_TWO [256] = '{
    8'h38,8'hE8,8'h2D,8'hA6,8'hCF,8'hDE,8'hB3,8'hB8,8'hAF,8'h60,8'h55,8'hC7,8'h44,8'h6F,8'h6B,8'h5B,
    8'hC3,8'h62,8'h33,8'hB5,8'h29,8'hA0,8'hE2,8'hA7,8'hD3,8'h91,8'h11,8'h06,8'h1C,8'hBC,8'h36,8'h4B,
    8'hEF,8'h88,8'h6C,8'hA8,8'h17,8'hC4,8'h16,8'hF4,8'hC2,8'h45,8'hE1,8'hD6,8'h3F,8'h3D,8'h8E,8'h98,
    8'h28,8'h4E,8'hF6,8'h3E,8'hA5,8'hF9,8'h0D,8'hDF,8'hD8,8'h2B,8'h66,8'h7A,8'h27,8'h2F,8'hF1,8'h72,
    8'h42,8'hD4,8'h41,8'hC0,8'h73,8'h67,8'hAC,8'h8B,8'hF7,8'hAD,8'h80,8'h1F,8'hCA,8'h2C,8'hAA,8'h34,
    8'hD2,8'h0B,8'hEE,8'hE9,8'h5D,8'h94,8'h18,8'hF8,8'h57,8'hAE,8'h08,8'hC5,8'h13,8'hCD,8'h86,8'hB9,
    8'hFF,8'h7D,8'hC1,8'h31,8'hF5,8'h8A,8'h6A,8'hB1,8'hD1,8'h20,8'hD7,8'h02,8'h22,8'h04,8'h68,8'h71,
    8'h07,8'hDB,8'h9D,8'h99,8'h61,8'hBE,8'hE6,8'h59,8'hDD,8'h51,8'h90,8'hDC,8'h9A,8'hA3,8'hAB,8'hD0,
    8'h81,8'h0F,8'h47,8'h1A,8'hE3,8'hEC,8'h8D,8'hBF,8'h96,8'h7B,8'h5C,8'hA2,8'hA1,8'h63,8'h23,8'h4D,
    8'hC8,8'h9E,8'h9C,8'h3A,8'h0C,8'h2E,8'hBA,8'h6E,8'h9F,8'h5A,8'hF2,8'h92,8'hF3,8'h49,8'h78,8'hCC,
    8'h15,8'hFB,8'h70,8'h75,8'h7F,8'h35,8'h10,8'h03,8'h64,8'h6D,8'hC6,8'h74,8'hD5,8'hB4,8'hEA,8'h09,
    8'h76,8'h19,8'hFE,8'h40,8'h12,8'hE0,8'hBD,8'h05,8'hFA,8'h01,8'hF0,8'h2A,8'h5E,8'hA9,8'h56,8'h43,
    8'h85,8'h14,8'h89,8'h9B,8'hB0,8'hE5,8'h48,8'h79,8'h97,8'hFC,8'h1E,8'h82,8'h21,8'h8C,8'h1B,8'h5F,
    8'h77,8'h54,8'hB2,8'h1D,8'h25,8'h4F,8'h00,8'h46,8'hED,8'h58,8'h52,8'hEB,8'h7E,8'hDA,8'hC9,8'hFD,
    8'h30,8'h95,8'h65,8'h3C,8'hB6,8'hE4,8'hBB,8'h7C,8'h0E,8'h50,8'h39,8'h26,8'h32,8'h84,8'h69,8'h93,
    8'h37,8'hE7,8'h24,8'hA4,8'hCB,8'h53,8'h0A,8'h87,8'hD9,8'h4C,8'h83,8'h8F,8'hCE,8'h3B,8'h4A,8'hB7
  };

endpackage

[src/seed_gfunc.sv]
// SEED G function: four S-box lookups and masked byte mixing
module seed_gfunc (
  input  logic [31:0] x,
  output logic [31:0] y
);
  import seed_pkg::*;

  logic [7:0] y0, y1, y2, y3;
  logic [7:0] z0, z1, z2, z3;

  always_comb begin
    y0 = SBOX_ONE[x[7:0]];
    y1 = SBOX_TWO[x[15:8]];
    y2 = SBOX_ONE[x[23:16]];
    y3 = SBOX_TWO[x[31:24]];
    z0 = (y0 & MASK_A) ^ (y1 & MASK_B) ^ (y2 & MASK_C) ^ (y3 & MASK_D);
    z1 = (y0 & MASK_B) ^ (y1 & MASK_C) ^ (y2 & MASK_D) ^ (y3 & MASK_A);
    z2 = (y0 & MASK_C) ^ (y1 & MASK_D) ^ (y2 & MASK_A) ^ (y3 & MASK_B);
    z3 = (y0 & MASK_D) ^ (y1 & MASK_A) ^ (y2 & MASK_B) ^ (y3 & MASK_C);
    y  = {z3, z2, z1, z0};
  end

endmodule

[src/seed_block_cipher_unit.sv]
// Channel  Ports                                  Handshake
// input    start, busy, in_data                   start & !busy
// result   out_strobe, out_data                   one-cycle strobe
// config   cfg_valid, cfg_ready, cfg_index, cfg_data  valid & ready
//
// One shared G unit is used once per cycle. A key write computes all 32
// round-key words in ST_KEY before the next block is taken. A block runs
// 16 rounds of three G passes, then shows the result in ST_DONE. Round
// keys live in a 32-word memory; both words of a round are read together,
// registered the cycle before use. Reset is synchronous; key registers
// clear to zero. In idle a start wins over a configuration write. The
// receiver cannot stall: the result strobe lasts one cycle.
module seed_block_cipher_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  seed_pkg::seed_in_t in_data,
  output logic               out_strobe,
  output seed_pkg::seed_out_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [63:0]        cfg_data
);
  import seed_pkg::*;

  seed_state_t state_r, state_nxt;
  logic [63:0] key_high_r, key_low_r;
  logic [31:0] ka_r, kb_r, kc_r, kd_r, kcon_r;
  logic [4:0]  cnt_r;        // key word index (round * 2 + half) or round number
  logic        dec_r;
  logic [31:0] l0_r, l1_r, r0_r, r1_r, t0_r, t1_r;
  logic [31:0] rk_mem [32];
  logic [31:0] g_in, g_out;
  logic        cfg_wr;
  logic [31:0] rd_data_r, rd_odd_r;

  assign cfg_ready  = (state_r == ST_IDLE) && !start;
  assign busy       = (state_r != ST_IDLE);
  assign cfg_wr     = cfg_valid && cfg_ready &&
                      (cfg_index == CFG_KEY_HIGH || cfg_index == CFG_KEY_LOW);
  assign out_strobe = (state_r == ST_DONE);
  assign out_data   = '{out_high: {r0_r, r1_r}, out_low: {l0_r, l1_r}};

  // key schedule temporaries
  logic [31:0] kt0, kt1;
  assign kt0 = ka_r + kc_r - kcon_r;
  assign kt1 = kb_r - kd_r + kcon_r;

  // shared G unit input select
  always_comb begin
    unique case (state_r)
      ST_KEY:  g_in = cnt_r[0] ? kt1 : kt0;
      ST_G0:   g_in = (r0_r ^ rd_data_r) ^ (r1_r ^ rd_odd_r);
      ST_G1:   g_in = t0_r + t1_r;
      ST_G2:   g_in = t0_r + t1_r;
      default: g_in = t0_r + t1_r;
    endcase
  end

  seed_gfunc u_g (.x(g_in), .y(g_out));

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_G0;
        else if (cfg_wr) state_nxt = ST_KEY;
      end
      ST_KEY:  if (cnt_r == 5'd31) state_nxt = ST_IDLE;
      ST_G0:   state_nxt = ST_G1;
      ST_G1:   state_nxt = ST_G2;
      ST_G2:   state_nxt = (cnt_r[3:0] == 4'd15) ? ST_DONE : ST_G0;
      ST_DONE: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      key_high_r <= '0;
      key_low_r  <= '0;
      cnt_r      <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr) begin
        cnt_r <= '0;
        if (cfg_index == CFG_KEY_HIGH) key_high_r <= cfg_data;
        else key_low_r <= cfg_data;
      end else if (state_r == ST_IDLE && start) begin
        cnt_r <= '0;
      end else if (state_r == ST_KEY) begin
        cnt_r <= cnt_r + 5'd1;
      end else if (state_r == ST_G2) begin
        cnt_r <= {1'b0, cnt_r[3:0] + 4'd1};
      end
    end
  end

  // key schedule working words: loaded on a key write, stepped per round
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && cfg_wr) begin
      ka_r   <= (cfg_index == CFG_KEY_HIGH) ? cfg_data[63:32] : key_high_r[63:32];
      kb_r   <= (cfg_index == CFG_KEY_HIGH) ? cfg_data[31:0]  : key_high_r[31:0];
      kc_r   <= (cfg_index == CFG_KEY_LOW)  ? cfg_data[63:32] : key_low_r[63:32];
      kd_r   <= (cfg_index == CFG_KEY_LOW)  ? cfg_data[31:0]  : key_low_r[31:0];
      kcon_r <= GOLDEN_KC;
    end else if (state_r == ST_KEY && cnt_r[0]) begin
      if (!cnt_r[1]) begin
        ka_r <= (ka_r >> 8) ^ (kb_r << 24);
        kb_r <= (kb_r >> 8) ^ (ka_r << 24);
      end else begin
        kc_r <= (kc_r << 8) ^ (kd_r >> 24);
        kd_r <= (kd_r << 8) ^ (kc_r >> 24);
      end
      kcon_r <= {kcon_r[30:0], kcon_r[31]};
    end
  end

  // round-key memory: written during the schedule, a word pair read per cycle
  logic [4:0] rd_addr;
  always_comb begin
    unique case (state_r)
      ST_IDLE: rd_addr = in_data.cmd ? 5'd30 : 5'd0;
      default: rd_addr = dec_r ? {4'd14 - cnt_r[3:0], 1'b0}
                               : {cnt_r[3:0] + 4'd1, 1'b0};
    endcase
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_KEY) rk_mem[cnt_r] <= g_out;
    rd_data_r <= rk_mem[rd_addr];
    rd_odd_r  <= rk_mem[{rd_addr[4:1], 1'b1}];
  end

  // datapath: three G passes per round
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          dec_r <= in_data.cmd;
          l0_r  <= in_data.block_high[63:32];
          l1_r  <= in_data.block_high[31:0];
          r0_r  <= in_data.block_low[63:32];
          r1_r  <= in_data.block_low[31:0];
        end
      end
      ST_G0: begin
        // both words of the round's pair arrived last cycle
        t0_r <= r0_r ^ rd_data_r;
        t1_r <= g_out;
      end
      ST_G1: begin
        t0_r <= g_out;
        t1_r <= t1_r;
      end
      ST_G2: begin
        l0_r <= r0_r;
        l1_r <= r1_r;
        r0_r <= l0_r ^ (t0_r + g_out);
        r1_r <= l1_r ^ g_out;
      end
      default: ;
    endcase
  end

endmodule

[src/seed_block_cipher_unit_checker.sv]
`include "seed_block_cipher_unit_defines.svh"
module seed_block_cipher_unit_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_strobe,
  input logic cfg_valid,
  input logic cfg_ready
);
  // a result strobe is never held high
  `SEED_ASSERT_NEXT(a_strobe_single, clk, rst_n, out_strobe, !out_strobe, "strobe held")
  // an accepted block makes the block busy
  `SEED_ASSERT_NEXT(a_start_busy, clk, rst_n, start && !busy && !cfg_valid, busy, "not busy")
  // configuration is refused while busy
  `SEED_ASSERT_IMP(a_cfg_idle, clk, rst_n, busy, !cfg_ready, "cfg ready while busy")
  // result appears only at the end of work
  `SEED_ASSERT_IMP(a_strobe_busy, clk, rst_n, out_strobe, busy, "strobe when idle")
endmodule

bind seed_block_cipher_unit seed_block_cipher_unit_checker u_chk (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
  .out_strobe(out_strobe), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready)
);
